FILE: hw/rtl/dqs_pkg.sv
// Package for the double-ended queue with search: sizes, request and status
// codes, controller states, and the command/status bundles between modules.
// No dependencies.
package dqs_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int STS_W = 2;
    localparam int OUT_W = STS_W + 1 + CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_SEARCH = 1'b1
    } fsm_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;        // run a non-search request (or empty search) now
        logic srch_start;  // latch key, clear scan pointer
        logic srch_step;   // issue one slot read
        logic srch_done;   // write search result
    } dqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic occ_zero;
        logic rd_more;     // scan pointer below occupancy
        logic cmp_vld;     // read data valid for compare
        logic cmp_hit;
        logic cmp_last;    // compared word is the last held one
    } dqs_sts_t;

    // circular index: base + off, off known to be at most DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dqs_datapath.sv
// Datapath of the deque: slot memory, front pointer, occupancy, search
// scan pointer and compare, and the output register.
// Depends on dqs_pkg.
module dqs_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [dqs_pkg::OP_W-1:0]    op_in,
    input  logic [dqs_pkg::VAL_W-1:0]   value_in,
    input  dqs_pkg::dqs_cmd_t           cmd,
    output dqs_pkg::dqs_sts_t           sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dqs_pkg::OUT_W-1:0]   m_tdata
);
    import dqs_pkg::*;

    logic signed [VAL_W-1:0] slots [DEPTH];

    logic [IDX_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic signed [VAL_W-1:0] key_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    cmp_vld_reg;
    logic                    cmp_last_reg;

    logic                    out_vld_reg;
    status_t                 out_status_reg;
    logic                    out_found_reg;
    logic [CNT_W-1:0]        out_count_reg;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    status_t                 ex_status;
    logic [IDX_W-1:0]        rd_addr;
    logic                    occ_full;

    assign occ_full = (occ_reg == CNT_W'(DEPTH));
    assign rd_addr  = wrap_add(front_reg, rd_idx_reg);

    // request decode for requests that need no scan
    always_comb begin
        front_next = front_reg;
        occ_next   = occ_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        ex_status  = ST_OK;
        unique case (op_t'(op_in))
            OP_PUSH_FRONT: begin
                if (occ_full) begin
                    ex_status = ST_FULL;
                end else begin
                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                   : front_reg - 1'b1;
                    wr_addr    = front_next;
                    wr_en      = 1'b1;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (occ_full) begin
                    ex_status = ST_FULL;
                end else begin
                    wr_addr  = wrap_add(front_reg, occ_reg);
                    wr_en    = 1'b1;
                    occ_next = occ_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (occ_reg == '0) begin
                    ex_status = ST_EMPTY;
                end else begin
                    front_next = wrap_add(front_reg, CNT_W'(1));
                    occ_next   = occ_reg - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (occ_reg == '0) begin
                    ex_status = ST_EMPTY;
                end else begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            default: begin
                // search on an empty queue and unused codes: no change
            end
        endcase
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            occ_reg   <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
        end
    end

    // slot memory: one write port, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            slots[wr_addr] <= value_in;
        end
        if (cmd.srch_step) begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.srch_start) begin
            key_reg <= value_in;
        end
        if (cmd.srch_step) begin
            cmp_last_reg <= (rd_idx_reg == occ_reg - 1'b1);
        end
    end

    // scan control; compare runs in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.srch_start) begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.srch_step) begin
            cmp_vld_reg <= sts.rd_more;
            if (sts.rd_more) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end else begin
            cmp_vld_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.exec || cmd.srch_done) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_status_reg <= ex_status;
            out_found_reg  <= 1'b0;
            out_count_reg  <= occ_next;
        end else if (cmd.srch_done) begin
            out_status_reg <= ST_OK;
            out_found_reg  <= sts.cmp_hit;
            out_count_reg  <= occ_reg;
        end
    end

    assign sts.out_free = !out_vld_reg || m_tready;
    assign sts.occ_zero = (occ_reg == '0);
    assign sts.rd_more  = (rd_idx_reg < occ_reg);
    assign sts.cmp_vld  = cmp_vld_reg;
    assign sts.cmp_hit  = (rd_data_reg == key_reg);
    assign sts.cmp_last = cmp_last_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_count_reg, out_found_reg, out_status_reg};

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && occ_full &&
         (op_in == OP_PUSH_FRONT || op_in == OP_PUSH_BACK))
        |=> ($stable(occ_reg) && $stable(front_reg)))
        else $error("refused push changed queue state");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.srch_done) |-> sts.out_free)
        else $error("result written over an untaken one");
`endif

endmodule

FILE: hw/rtl/dqs_ctrl.sv
// Controller of the deque: accepts requests and sequences the slot scan of
// a search. Drives the datapath only through dqs_cmd_t / dqs_sts_t.
// Depends on dqs_pkg.
module dqs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dqs_pkg::OP_W-1:0]    op_in,
    input  dqs_pkg::dqs_sts_t           sts,
    output dqs_pkg::dqs_cmd_t           cmd
);
    import dqs_pkg::*;

    fsm_t state_reg, state_next;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = sts.out_free;
                if (accept) begin
                    if (op_in == OP_SEARCH && !sts.occ_zero) begin
                        cmd.srch_start = 1'b1;
                        state_next     = FSM_SEARCH;
                    end else begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            FSM_SEARCH: begin
                cmd.srch_step = 1'b1;
                if (sts.cmp_vld && (sts.cmp_hit || sts.cmp_last)) begin
                    cmd.srch_done = 1'b1;
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SEARCH) |-> (sts.rd_more || sts.cmp_vld))
        else $error("search scan stalled with nothing left to compare");
`endif

endmodule

FILE: hw/rtl/deque_with_search.sv
// Top level of the double-ended queue with linear search.
// Depends on dqs_pkg, dqs_ctrl and dqs_datapath.
//
// Bounded deque of DEPTH (16) signed 32-bit words. Each item on s_ is one
// request (push front, push back, pop front, pop back, search) and yields
// exactly one item on m_: status, found flag and the count after the request.
// Pushes, pops, unused codes and a search of an empty queue are executed when
// they are accepted. A search of a non-empty queue holds s_tready low while
// its scan runs. The slot memory has a single registered read port, the
// scan walks it one word per cycle, and the compare runs in the cycle after
// the read. The scan stops at the first match. The
// result sits in an output register, so a new request is taken in the same
// cycle the previous result is taken.
module deque_with_search (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dqs_pkg::VAL_W-1:0]   s_tdata,   // [31:0] value
    input  logic [dqs_pkg::OP_W-1:0]    s_tuser,   // [2:0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dqs_pkg::OUT_W-1:0]   m_tdata    // [1:0] status, [2] found, [7:3] count
);
    import dqs_pkg::*;

    dqs_cmd_t cmd;
    dqs_sts_t sts;

    dqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_in    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    dqs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_in    (s_tuser),
        .value_in (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: tb/tb_deque_with_search.sv
`timescale 1ns / 100ps
// Testbench for deque_with_search: directed table, then random request traffic.
// Each result is checked against a deque model or a fixed row. Depends on dqs_pkg.
module tb_deque_with_search;
    import dqs_pkg::*;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;
    localparam int N_RANDOM  = 1100;
    localparam int IDLE_PCT  = 32;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [CNT_W-1:0] count;
    } dq_result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        int               reps;
        bit               fixed;    // expected result typed in below
        dq_result_t       want;
    } dir_row_t;

    localparam int DIR_ROWS = 14;
    dir_row_t dir_tab [DIR_ROWS] = '{
        // empty after reset
        '{OP_POP_FRONT,    32'h0000_0000, 1, 1'b1, '{ST_EMPTY, 1'b0, 5'd0}},
        '{OP_POP_BACK,     32'hFFFF_FFFF, 1, 1'b1, '{ST_EMPTY, 1'b0, 5'd0}},
        '{OP_SEARCH,       32'h0000_0000, 1, 1'b1, '{ST_OK,    1'b0, 5'd0}},
        '{OP_FIRST_UNUSED, 32'h0000_0000, 1, 1'b1, '{ST_OK,    1'b0, 5'd0}},
        // extremes of the word
        '{OP_PUSH_FRONT,   32'h7FFF_FFFF, 1, 1'b1, '{ST_OK,    1'b0, 5'd1}},
        '{OP_PUSH_BACK,    32'h8000_0000, 1, 1'b1, '{ST_OK,    1'b0, 5'd2}},
        '{OP_SEARCH,       32'h8000_0000, 1, 1'b0, '{ST_OK,    1'b0, 5'd0}},
        '{OP_POP_FRONT,    32'h0000_0000, 1, 1'b0, '{ST_OK,    1'b0, 5'd0}},
        // popping the last word empties the queue
        '{OP_POP_BACK,     32'h0000_0000, 1, 1'b1, '{ST_OK,    1'b0, 5'd0}},
        // fill up, front index wraps below zero
        '{OP_PUSH_FRONT,   32'h5A5A_5A5A, 8, 1'b0, '{ST_OK,    1'b0, 5'd0}},
        '{OP_PUSH_BACK,    32'hA5A5_A5A5, 8, 1'b0, '{ST_OK,    1'b0, 5'd0}},
        '{OP_PUSH_BACK,    32'h1234_5678, 1, 1'b1, '{ST_FULL,  1'b0, 5'd16}},
        '{OP_PUSH_FRONT,   32'h0000_0001, 1, 1'b1, '{ST_FULL,  1'b0, 5'd16}},
        '{OP_SEARCH,       32'hA5A5_A5A5, 1, 1'b0, '{ST_OK,    1'b0, 5'd0}}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [VAL_W-1:0]    s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    // deque model
    logic [VAL_W-1:0]    dq_slots [DEPTH];
    logic [IDX_W-1:0]    dq_front;
    logic [CNT_W-1:0]    dq_occ;

    dq_result_t          pending_q [$];
    int                  err_cnt;
    int                  res_cnt;
    bit                  tx_idle_on;
    bit                  rx_idle_on;
    bit                  row_fixed;
    dq_result_t          row_want;
    logic [VAL_W-1:0]    val_pool [8];

    deque_with_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic dq_result_t apply_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
        dq_result_t r;
        int i;
        r.status = ST_OK;
        r.found  = 1'b0;
        case (op)
            OP_PUSH_FRONT: begin
                if (dq_occ == CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    dq_front = IDX_W'((int'(dq_front) + DEPTH - 1) % DEPTH);
                    dq_slots[dq_front] = val;
                    dq_occ = dq_occ + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (dq_occ == CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    dq_slots[IDX_W'((int'(dq_front) + int'(dq_occ)) % DEPTH)] = val;
                    dq_occ = dq_occ + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (dq_occ == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    dq_front = IDX_W'((int'(dq_front) + 1) % DEPTH);
                    dq_occ = dq_occ - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (dq_occ == 0) r.status = ST_EMPTY;
                else dq_occ = dq_occ - 1'b1;
            end
            OP_SEARCH: begin
                for (i = 0; i < int'(dq_occ); i++) begin
                    if (dq_slots[IDX_W'((int'(dq_front) + i) % DEPTH)] == val)
                        r.found = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = dq_occ;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        err_cnt++;
        $display("ERROR: result %0d %s: got %0d, expected %0d", res_cnt, field, got, want);
    endtask

    // check results, then record the request taken at the same edge
    always @(posedge aclk) begin
        dq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("with no request pending", int'(m_tdata), 0);
                end else begin
                    want = pending_q.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
                    if (m_tdata[2] !== want.found)
                        report_mismatch("found", int'(m_tdata[2]), int'(want.found));
                    if (m_tdata[7:3] !== want.count)
                        report_mismatch("count", int'(m_tdata[7:3]), int'(want.count));
                end
                res_cnt++;
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata);
                if (row_fixed) want = row_want;
                pending_q.push_back(want);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (rx_idle_on) m_tready <= ($urandom_range(99) >= IDLE_PCT);
        else m_tready <= 1'b1;
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                            input bit fixed, input dq_result_t want);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= val;
        row_fixed <= fixed;
        row_want  <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [OP_W-1:0] OP_OP_unused_pick();
        return OP_W'($urandom_range(int'(OP_LAST_UNUSED), int'(OP_FIRST_UNUSED)));
    endfunction

    initial begin
        int r, n, k, phase, push_w;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        row_fixed  = 1'b0;
        row_want   = '0;
        err_cnt    = 0;
        res_cnt    = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        dq_front   = '0;
        dq_occ     = '0;
        for (k = 0; k < DEPTH; k++) dq_slots[IDX_W'(k)] = '0;
        val_pool[0] = 32'h0000_0000;
        val_pool[1] = 32'hFFFF_FFFF;
        val_pool[2] = 32'h7FFF_FFFF;
        val_pool[3] = 32'h8000_0000;
        for (k = 4; k < 8; k++) val_pool[3'(k)] = $urandom;
        aresetn = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            for (k = 0; k < dir_tab[i].reps; k++)
                send_req(dir_tab[i].op, dir_tab[i].value, dir_tab[i].fixed, dir_tab[i].want);
        end
        s_tvalid  <= 1'b0;
        row_fixed <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge aclk);

        for (n = 0; n < N_RANDOM; n++) begin
            tx_idle_on = !(n >= 400 && n < 600);
            rx_idle_on = tx_idle_on;
            if (n == 700) begin
                // hold off until the queue of results has drained
                s_tvalid <= 1'b0;
                wait (pending_q.size() == 0);
                @(negedge aclk);
            end
            // alternate push-heavy, pop-heavy and balanced stretches
            phase  = (n / 60) % 3;
            push_w = (phase == 0) ? 56 : (phase == 1) ? 20 : 38;
            r = $urandom_range(99);
            if (r < 4) op = OP_OP_unused_pick();
            else if (r < 24) op = OP_SEARCH;
            else if (r < 24 + push_w) op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            val = $urandom_range(1) ? val_pool[3'($urandom_range(7))] : $urandom;
            if (op == OP_SEARCH && dq_occ != 0 && $urandom_range(1))
                val = dq_slots[IDX_W'((int'(dq_front) + $urandom_range(int'(dq_occ) - 1))
                                      % DEPTH)];
            send_req(op, val, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (DEPTH + 8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
